// ----- rtl/uart_trb_pkg.sv -----
// Shared types, codes and default sizes for the two-port UART ring buffers.
// No dependencies; imported by every module in rtl/.
package uart_trb_pkg;

    localparam int DEF_TX_DEPTH   = 64;
    localparam int DEF_RX_DEPTH   = 64;
    localparam int DEF_PORT_COUNT = 2;

    // Item modes
    localparam logic [2:0] MODE_HOST_WRITE = 3'd0;
    localparam logic [2:0] MODE_HOST_READ  = 3'd1;
    localparam logic [2:0] MODE_TX_DONE    = 3'd2;
    localparam logic [2:0] MODE_RX_BYTE    = 3'd3;
    localparam logic [2:0] MODE_CHECK_OVF  = 3'd4;

    // Result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_TX_FULL  = 2'd1;
    localparam logic [1:0] STS_RX_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic       port;
        logic [7:0] data_byte;
        logic       tx_reg_empty;
        logic       rx_error;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       tx_load;
        logic [7:0] tx_byte;
        logic       overflow_flag;
    } out_item_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_RESP
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic respond;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/uart_trb_ctl.sv -----
// Sequencing state machine: capture, execute, respond.
// Depends on uart_trb_pkg.
module uart_trb_ctl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output uart_trb_pkg::ctl_cmd_t cmd,
    input  uart_trb_pkg::dp_status_t sts
);
    import uart_trb_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                state_next = CTL_RESP;
            end
            CTL_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.respond = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            CTL_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            CTL_RESP:
            begin
                cmd.respond = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/uart_trb_dp.sv -----
// Datapath: per-port pointers, counts, overflow flags, queue memories, result register.
// Depends on uart_trb_pkg.
module uart_trb_dp #(
    parameter int TX_DEPTH   = uart_trb_pkg::DEF_TX_DEPTH,
    parameter int RX_DEPTH   = uart_trb_pkg::DEF_RX_DEPTH,
    parameter int PORT_COUNT = uart_trb_pkg::DEF_PORT_COUNT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  uart_trb_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output uart_trb_pkg::out_item_t  out_data,
    input  uart_trb_pkg::ctl_cmd_t   cmd,
    output uart_trb_pkg::dp_status_t sts
);
    import uart_trb_pkg::*;

    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_AW = $clog2(PORT_COUNT * TX_DEPTH);
    localparam int RX_AW = $clog2(PORT_COUNT * RX_DEPTH);
    localparam int TX_ENTRIES = PORT_COUNT * TX_DEPTH;
    localparam int RX_ENTRIES = PORT_COUNT * RX_DEPTH;

    // Per-port control state
    logic [TX_PW-1:0] tx_wptr_reg [PORT_COUNT];
    logic [TX_PW-1:0] tx_rptr_reg [PORT_COUNT];
    logic [TX_CW-1:0] tx_cnt_reg  [PORT_COUNT];
    logic [RX_PW-1:0] rx_wptr_reg [PORT_COUNT];
    logic [RX_PW-1:0] rx_rptr_reg [PORT_COUNT];
    logic [RX_CW-1:0] rx_cnt_reg  [PORT_COUNT];
    logic             rx_ovf_reg  [PORT_COUNT];

    // Queue storage
    logic [7:0] tx_mem [TX_ENTRIES];
    logic [7:0] rx_mem [RX_ENTRIES];
    logic [7:0] tx_rdata_reg;
    logic [7:0] rx_rdata_reg;

    in_item_t  item_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    // Result fields decided at execute, finished at respond
    logic [1:0] pend_status_reg;
    logic       pend_rvalid_reg;
    logic       pend_tx_load_reg;
    logic       pend_tx_mem_reg;
    logic [7:0] pend_tx_byte_reg;
    logic       pend_ovf_reg;

    // Selected port view
    logic [TX_PW-1:0] sel_tx_wptr;
    logic [TX_PW-1:0] sel_tx_rptr;
    logic [TX_CW-1:0] sel_tx_cnt;
    logic [RX_PW-1:0] sel_rx_wptr;
    logic [RX_PW-1:0] sel_rx_rptr;
    logic [RX_CW-1:0] sel_rx_cnt;
    logic             sel_rx_ovf;

    logic [TX_PW-1:0] tx_wptr_next;
    logic [TX_PW-1:0] tx_rptr_next;
    logic [RX_PW-1:0] rx_wptr_next;
    logic [RX_PW-1:0] rx_rptr_next;
    logic [RX_CW-1:0] rx_cnt_inc;

    logic port_ok;
    logic tx_push;
    logic tx_pop;
    logic rx_push;
    logic rx_pop;
    logic rx_wrap;
    logic ovf_clr;
    logic direct_load;
    logic [1:0] status_now;

    logic [TX_AW-1:0] tx_waddr;
    logic [TX_AW-1:0] tx_raddr;
    logic [RX_AW-1:0] rx_waddr;
    logic [RX_AW-1:0] rx_raddr;

    always_comb
    begin
        sel_tx_wptr = '0;
        sel_tx_rptr = '0;
        sel_tx_cnt  = '0;
        sel_rx_wptr = '0;
        sel_rx_rptr = '0;
        sel_rx_cnt  = '0;
        sel_rx_ovf  = 1'b0;
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            if (item_reg.port == 1'(p))
            begin
                sel_tx_wptr = tx_wptr_reg[p];
                sel_tx_rptr = tx_rptr_reg[p];
                sel_tx_cnt  = tx_cnt_reg[p];
                sel_rx_wptr = rx_wptr_reg[p];
                sel_rx_rptr = rx_rptr_reg[p];
                sel_rx_cnt  = rx_cnt_reg[p];
                sel_rx_ovf  = rx_ovf_reg[p];
            end
        end
    end

    assign port_ok = (PORT_COUNT > 1) || !item_reg.port;

    // Pointer wrap at depth, not at a power of two
    assign tx_wptr_next = (sel_tx_wptr == TX_PW'(TX_DEPTH - 1)) ? '0 : sel_tx_wptr + 1'b1;
    assign tx_rptr_next = (sel_tx_rptr == TX_PW'(TX_DEPTH - 1)) ? '0 : sel_tx_rptr + 1'b1;
    assign rx_wptr_next = (sel_rx_wptr == RX_PW'(RX_DEPTH - 1)) ? '0 : sel_rx_wptr + 1'b1;
    assign rx_rptr_next = (sel_rx_rptr == RX_PW'(RX_DEPTH - 1)) ? '0 : sel_rx_rptr + 1'b1;
    assign rx_cnt_inc   = sel_rx_cnt + 1'b1;

    always_comb
    begin
        tx_push     = 1'b0;
        tx_pop      = 1'b0;
        rx_push     = 1'b0;
        rx_pop      = 1'b0;
        rx_wrap     = 1'b0;
        ovf_clr     = 1'b0;
        direct_load = 1'b0;
        status_now  = STS_OK;
        if (cmd.execute && port_ok)
        begin
            unique case (item_reg.mode)
                MODE_HOST_WRITE:
                begin
                    if (sel_tx_cnt >= TX_CW'(TX_DEPTH))
                    begin
                        status_now = STS_TX_FULL;
                    end
                    else if ((sel_tx_cnt == '0) && item_reg.tx_reg_empty)
                    begin
                        direct_load = 1'b1;
                    end
                    else
                    begin
                        tx_push = 1'b1;
                    end
                end
                MODE_HOST_READ:
                begin
                    if (sel_rx_cnt == '0)
                    begin
                        status_now = STS_RX_EMPTY;
                    end
                    else
                    begin
                        rx_pop = 1'b1;
                    end
                end
                MODE_TX_DONE:
                begin
                    tx_pop = (sel_tx_cnt != '0);
                end
                MODE_RX_BYTE:
                begin
                    rx_push = !item_reg.rx_error;
                    rx_wrap = !item_reg.rx_error && (rx_cnt_inc >= RX_CW'(RX_DEPTH));
                end
                MODE_CHECK_OVF:
                begin
                    ovf_clr = 1'b1;
                end
                default:
                begin
                    status_now = STS_OK;
                end
            endcase
        end
    end

    // Flat address: port 1 sits above port 0's region
    assign tx_waddr = item_reg.port ? TX_AW'(TX_DEPTH) + TX_AW'(sel_tx_wptr) : TX_AW'(sel_tx_wptr);
    assign tx_raddr = item_reg.port ? TX_AW'(TX_DEPTH) + TX_AW'(sel_tx_rptr) : TX_AW'(sel_tx_rptr);
    assign rx_waddr = item_reg.port ? RX_AW'(RX_DEPTH) + RX_AW'(sel_rx_wptr) : RX_AW'(sel_rx_wptr);
    assign rx_raddr = item_reg.port ? RX_AW'(RX_DEPTH) + RX_AW'(sel_rx_rptr) : RX_AW'(sel_rx_rptr);

    always_ff @(posedge clk)
    begin
        if (tx_push)
        begin
            tx_mem[tx_waddr] <= item_reg.data_byte;
        end
        if (tx_pop)
        begin
            tx_rdata_reg <= tx_mem[tx_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_push)
        begin
            rx_mem[rx_waddr] <= item_reg.data_byte;
        end
        if (rx_pop)
        begin
            rx_rdata_reg <= rx_mem[rx_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                tx_wptr_reg[p] <= '0;
                tx_rptr_reg[p] <= '0;
                tx_cnt_reg[p]  <= '0;
                rx_wptr_reg[p] <= '0;
                rx_rptr_reg[p] <= '0;
                rx_cnt_reg[p]  <= '0;
                rx_ovf_reg[p]  <= 1'b0;
            end
        end
        else
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                if (item_reg.port == 1'(p))
                begin
                    if (tx_push)
                    begin
                        tx_wptr_reg[p] <= tx_wptr_next;
                        tx_cnt_reg[p]  <= sel_tx_cnt + 1'b1;
                    end
                    if (tx_pop)
                    begin
                        tx_rptr_reg[p] <= tx_rptr_next;
                        tx_cnt_reg[p]  <= sel_tx_cnt - 1'b1;
                    end
                    if (rx_push)
                    begin
                        rx_wptr_reg[p] <= rx_wptr_next;
                        rx_cnt_reg[p]  <= rx_wrap ? '0 : rx_cnt_inc;
                    end
                    if (rx_wrap)
                    begin
                        rx_ovf_reg[p] <= 1'b1;
                    end
                    if (rx_pop)
                    begin
                        rx_rptr_reg[p] <= rx_rptr_next;
                        rx_cnt_reg[p]  <= sel_rx_cnt - 1'b1;
                    end
                    if (ovf_clr)
                    begin
                        rx_ovf_reg[p] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.execute)
        begin
            pend_status_reg  <= status_now;
            pend_rvalid_reg  <= rx_pop;
            pend_tx_load_reg <= direct_load || tx_pop;
            pend_tx_mem_reg  <= tx_pop;
            pend_tx_byte_reg <= item_reg.data_byte;
            pend_ovf_reg     <= ovf_clr && sel_rx_ovf;
        end
        if (cmd.respond)
        begin
            out_reg.status        <= pend_status_reg;
            out_reg.read_valid    <= pend_rvalid_reg;
            out_reg.read_byte     <= pend_rvalid_reg ? rx_rdata_reg : 8'd0;
            out_reg.tx_load       <= pend_tx_load_reg;
            out_reg.tx_byte       <= !pend_tx_load_reg ? 8'd0 :
                                     (pend_tx_mem_reg ? tx_rdata_reg : pend_tx_byte_reg);
            out_reg.overflow_flag <= pend_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

endmodule

// ----- rtl/uart_tx_rx_ring_buffers.sv -----
// Top level of the two-port UART transmit/receive ring buffers.
// Depends on uart_trb_pkg, uart_trb_ctl and uart_trb_dp.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------
//  in      | into      | in_valid / in_stall  | in_data  (in_item_t)
//  out     | out of    | out_valid / out_stall| out_data (out_item_t)
//
// One transaction in gives exactly one transaction out.
// Each item goes through capture, execute (one access to the tx or rx
// queue memory, registered read), then loading of the result register.
// There is a single memory access per item, in the execute step.
// The result register lets the next item be taken while a result still waits;
// a held out_stall only holds back the respond step of the following item.
// rst_n clears pointers, counts and overflow flags at once; queue memories
// are not cleared and need no clearing pass.
module uart_tx_rx_ring_buffers #(
    parameter int TX_DEPTH   = uart_trb_pkg::DEF_TX_DEPTH,
    parameter int RX_DEPTH   = uart_trb_pkg::DEF_RX_DEPTH,
    parameter int PORT_COUNT = uart_trb_pkg::DEF_PORT_COUNT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  uart_trb_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output uart_trb_pkg::out_item_t out_data
);
    import uart_trb_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t sts;

    // Sequencer: one item in flight at a time
    uart_trb_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Queue state, memories and result register
    uart_trb_dp #(
        .TX_DEPTH   (TX_DEPTH),
        .RX_DEPTH   (RX_DEPTH),
        .PORT_COUNT (PORT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // An accepted item blocks further input until its result is loaded
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while one is in flight");

    // Respond always presents a result on the next cycle
    a_respond_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> out_valid)
        else $error("result not presented after respond");

    // Respond never overwrites a result that is held by the receiver
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> (!out_valid || !out_stall))
        else $error("held result overwritten");

    // A refused write never loads the transmitter; a dequeued byte means success
    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(out_data.status == STS_TX_FULL && out_data.tx_load)
                       && !(out_data.read_valid && out_data.status != STS_OK)))
        else $error("inconsistent result fields");

endmodule

// ----- verif/uart_tx_rx_ring_buffers_tb.sv -----
// Self-checking testbench for the two-port UART transmit/receive ring buffers.
// Depends on rtl/uart_trb_pkg.sv and rtl/uart_tx_rx_ring_buffers.sv, which needs uart_trb_ctl and uart_trb_dp.
// A scoreboard class predicts each result; plain tasks drive directed and burst-shaped traffic.
module uart_tx_rx_ring_buffers_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uart_trb_pkg::*;

    localparam int TX_DEPTH   = DEF_TX_DEPTH;
    localparam int RX_DEPTH   = DEF_RX_DEPTH;
    localparam int PORTS      = DEF_PORT_COUNT;
    localparam int TX_AW      = $clog2(TX_DEPTH);
    localparam int RX_AW      = $clog2(RX_DEPTH);

    localparam int ITEM_TARGET   = 1250;  // transactions with a defined mode, directed ones included
    localparam int CALM_FROM     = 500;   // stretch with no idling on either side
    localparam int CALM_TO       = 800;
    localparam int DRAIN_EVERY   = 12;    // bursts between full drains of the pipeline
    localparam int SETTLE_CYCLES = 12;    // plenty of margin after the final drain
    localparam int MAX_SHOWN     = 10;

    // Traffic shapes for the random part
    typedef enum logic [2:0] {
        BURST_TX_FILL,
        BURST_TX_DRAIN,
        BURST_RX_FILL,
        BURST_RX_DRAIN,
        BURST_MIXED,
        BURST_NOISE
    } burst_kind_t;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of both ports' queues, predicts one result per
    // accepted transaction and checks results in order.
    // ------------------------------------------------------------------
    class ring_scoreboard;
        bit [7:0]       tx_mem [PORTS][TX_DEPTH];
        bit [TX_AW-1:0] tx_wr  [PORTS];
        bit [TX_AW-1:0] tx_rd  [PORTS];
        bit [TX_AW:0]   tx_cnt [PORTS];
        bit [7:0]       rx_mem [PORTS][RX_DEPTH];
        bit [RX_AW-1:0] rx_wr  [PORTS];
        bit [RX_AW-1:0] rx_rd  [PORTS];
        bit [RX_AW:0]   rx_cnt [PORTS];
        bit             rx_ovf [PORTS];

        out_item_t      due_responses [$];
        int unsigned    mismatches;

        function out_item_t predict_response(in_item_t it);
            out_item_t r;
            int        p;
            r = '0;
            p = int'(it.port);
            if (p < PORTS)
            begin
                case (it.mode)
                    MODE_HOST_WRITE:
                    begin
                        if (tx_cnt[p] >= TX_DEPTH)
                        begin
                            r.status = STS_TX_FULL;
                        end
                        else if (tx_cnt[p] == 0 && it.tx_reg_empty)
                        begin
                            // empty queue, free register: straight to the transmitter
                            r.tx_load = 1'b1;
                            r.tx_byte = it.data_byte;
                        end
                        else
                        begin
                            tx_mem[p][tx_wr[p]] = it.data_byte;
                            tx_wr[p] = (tx_wr[p] == TX_DEPTH - 1) ? '0 : tx_wr[p] + 1'b1;
                            tx_cnt[p]++;
                        end
                    end
                    MODE_HOST_READ:
                    begin
                        if (rx_cnt[p] == 0)
                        begin
                            r.status = STS_RX_EMPTY;
                        end
                        else
                        begin
                            r.read_valid = 1'b1;
                            r.read_byte  = rx_mem[p][rx_rd[p]];
                            rx_rd[p] = (rx_rd[p] == RX_DEPTH - 1) ? '0 : rx_rd[p] + 1'b1;
                            rx_cnt[p]--;
                        end
                    end
                    MODE_TX_DONE:
                    begin
                        if (tx_cnt[p] != 0)
                        begin
                            r.tx_load = 1'b1;
                            r.tx_byte = tx_mem[p][tx_rd[p]];
                            tx_rd[p] = (tx_rd[p] == TX_DEPTH - 1) ? '0 : tx_rd[p] + 1'b1;
                            tx_cnt[p]--;
                        end
                    end
                    MODE_RX_BYTE:
                    begin
                        if (!it.rx_error)
                        begin
                            rx_mem[p][rx_wr[p]] = it.data_byte;
                            rx_wr[p] = (rx_wr[p] == RX_DEPTH - 1) ? '0 : rx_wr[p] + 1'b1;
                            rx_cnt[p]++;
                            // count wraps to zero on reaching depth, pointers carry on
                            if (rx_cnt[p] >= RX_DEPTH)
                            begin
                                rx_cnt[p] = '0;
                                rx_ovf[p] = 1'b1;
                            end
                        end
                    end
                    MODE_CHECK_OVF:
                    begin
                        r.overflow_flag = rx_ovf[p];
                        rx_ovf[p] = 1'b0;
                    end
                    default: ;
                endcase
            end
            return r;
        endfunction

        function void note_transaction(in_item_t it);
            due_responses.push_back(predict_response(it));
        endfunction

        function void log_mismatch(string what, out_item_t want, out_item_t got);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("[%0t] mismatch %0d (%s):", $realtime, mismatches, what);
            if (mismatches <= MAX_SHOWN)
                $display("    exp sts=%0d rv=%0d rb=%02h ld=%0d tb=%02h ovf=%0d",
                         want.status, want.read_valid, want.read_byte, want.tx_load,
                         want.tx_byte, want.overflow_flag);
            if (mismatches <= MAX_SHOWN)
                $display("    got sts=%0d rv=%0d rb=%02h ld=%0d tb=%02h ovf=%0d",
                         got.status, got.read_valid, got.read_byte, got.tx_load,
                         got.tx_byte, got.overflow_flag);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (due_responses.size() == 0)
            begin
                log_mismatch("no transaction due", '0, got);
                return;
            end
            want = due_responses.pop_front();
            if (got.status        !== want.status     ||
                got.read_valid    !== want.read_valid ||
                got.read_byte     !== want.read_byte  ||
                got.tx_load       !== want.tx_load    ||
                got.tx_byte       !== want.tx_byte    ||
                got.overflow_flag !== want.overflow_flag)
                log_mismatch("field differs", want, got);
        endfunction

        function int pending();
            return due_responses.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    ring_scoreboard sb;
    int             items_sent = 0;
    bit             calm       = 1'b0;   // set during the no-idling stretch

    uart_tx_rx_ring_buffers u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: stalls at random about 8 percent of the time, never during the calm stretch.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 8);

    // Result monitor. Sampled at the edge, so pre-edge values are seen.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------
    function automatic in_item_t make_item(logic [2:0] mode, logic port, logic [7:0] data,
                                           logic reg_free, logic err);
        in_item_t it;
        it.mode         = mode;
        it.port         = port;
        it.data_byte    = data;
        it.tx_reg_empty = reg_free;
        it.rx_error     = err;
        return it;
    endfunction

    // Random content; errors on received bytes kept rare so the queues fill.
    function automatic in_item_t rand_item(logic [2:0] mode, logic port);
        return make_item(mode, port, 8'($urandom), 1'($urandom),
                         $urandom_range(0, 7) == 0);
    endfunction

    // One transaction. Valid stays high into the next call unless a gap is
    // drawn, so valid is never lowered and raised in the same step.
    task automatic send_item(in_item_t it);
        while (!calm && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transaction(it);
        if (it.mode <= MODE_CHECK_OVF)
            items_sent++;
        calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
    endtask

    // Sender holds off until every predicted result has been seen.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Directed: empty-queue cases, bypass vs queueing, extremes of the byte,
    // dropped errored byte, ignored modes and the overflow check from reset.
    task automatic run_directed();
        send_item(make_item(MODE_HOST_READ,  1'b0, 8'h00, 1'b0, 1'b0)); // empty rx
        send_item(make_item(MODE_HOST_READ,  1'b1, 8'hFF, 1'b1, 1'b1)); // empty rx
        send_item(make_item(MODE_TX_DONE,    1'b0, 8'hFF, 1'b1, 1'b1)); // nothing queued
        send_item(make_item(MODE_CHECK_OVF,  1'b1, 8'h00, 1'b0, 1'b0)); // flag clear
        send_item(make_item(MODE_HOST_WRITE, 1'b0, 8'h00, 1'b1, 1'b0)); // bypass
        send_item(make_item(MODE_HOST_WRITE, 1'b0, 8'hFF, 1'b0, 1'b1)); // reg busy: queued
        send_item(make_item(MODE_HOST_WRITE, 1'b0, 8'hA5, 1'b1, 1'b0)); // queue not empty
        send_item(make_item(MODE_TX_DONE,    1'b0, 8'h00, 1'b0, 1'b0));
        send_item(make_item(MODE_TX_DONE,    1'b0, 8'h00, 1'b0, 1'b0));
        send_item(make_item(MODE_TX_DONE,    1'b0, 8'h00, 1'b0, 1'b0)); // now empty
        send_item(make_item(MODE_RX_BYTE,    1'b1, 8'hFF, 1'b0, 1'b1)); // dropped
        send_item(make_item(MODE_RX_BYTE,    1'b1, 8'h00, 1'b1, 1'b0));
        send_item(make_item(MODE_RX_BYTE,    1'b1, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(MODE_HOST_READ,  1'b1, 8'h00, 1'b0, 1'b0));
        send_item(make_item(MODE_HOST_READ,  1'b1, 8'h00, 1'b0, 1'b0));
        send_item(make_item(MODE_HOST_READ,  1'b1, 8'h00, 1'b0, 1'b0)); // empty again
        send_item(make_item(3'd5,            1'b0, 8'hFF, 1'b1, 1'b1)); // unused modes
        send_item(make_item(3'd6,            1'b1, 8'hFF, 1'b1, 1'b1));
        send_item(make_item(3'd7,            1'b1, 8'hFF, 1'b1, 1'b1));
        send_item(make_item(MODE_HOST_WRITE, 1'b1, 8'h5A, 1'b1, 1'b1)); // bypass port 1
        send_item(make_item(MODE_CHECK_OVF,  1'b0, 8'hFF, 1'b1, 1'b1));
    endtask

    // Random: bursts of one kind on one port so that queues fill to the
    // refusal point and the receive count wraps, mixed with noise.
    task automatic run_random();
        burst_kind_t kind;
        int          len;
        int          bursts;
        logic        port;
        logic [2:0]  mode;
        in_item_t    it;
        bursts = 0;
        while (items_sent < ITEM_TARGET)
        begin
            kind = burst_kind_t'($urandom_range(BURST_TX_FILL, BURST_NOISE));
            port = 1'($urandom);
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 72)
                                               : $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    BURST_TX_FILL:  it = rand_item(MODE_HOST_WRITE, port);
                    BURST_TX_DRAIN: it = rand_item(MODE_TX_DONE, port);
                    BURST_RX_FILL:  it = rand_item(MODE_RX_BYTE, port);
                    BURST_RX_DRAIN: it = rand_item(MODE_HOST_READ, port);
                    BURST_MIXED:
                    begin
                        mode = 3'($urandom_range(MODE_HOST_WRITE, MODE_CHECK_OVF));
                        it   = rand_item(mode, port);
                    end
                    default:
                    begin
                        it = in_item_t'($bits(in_item_t)'($urandom));
                    end
                endcase
                send_item(it);
            end
            bursts++;
            if (bursts % DRAIN_EVERY == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
